@@ hw/rtl/ffha_pkg.sv @@
`default_nettype none

package ffha_pkg;

  localparam int unsigned HEAP_BYTES_DEF = 4096;
  localparam int unsigned MAX_BLOCKS_DEF = 64;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned REQ_W     = 13;
  localparam int unsigned SIZE_W    = 13;
  localparam int unsigned NEED_W    = REQ_W + 1;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned HDR_BYTES = 8;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_SIZE = 1'd1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // A grant of a new block and an accepted free share the same code.
  localparam logic [STAT_W-1:0] STAT_NEW     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_REUSED  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOSPACE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd3;

  localparam logic [SIZE_W-1:0] HEAP_SIZE_RST = 13'd4096;

endpackage

`default_nettype wire

@@ hw/rtl/ffha_ram.sv @@
`default_nettype none

module ffha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/first_fit_heap_allocator.sv @@
`default_nettype none

// First-fit heap allocator. Each input item is an allocate or a free request and gives
// exactly one result item. The block table lives in a single RAM that is scanned one
// entry per cycle in creation order through its one read port. An allocate that finds no
// freed block that fits then places a new block at the heap top, and a result waits while
// the output is stalled. A free of address zero and a free on an empty table skip the
// scan, and an allocate on an empty table goes straight to placing a new block. The block
// stays stalled while an item is in work.
// Only the first block_total table entries are ever read, so no clearing pass follows
// reset. Configuration may be written whenever no item is in work.

module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int unsigned HEAP_BYTES = HEAP_BYTES_DEF,
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_cmd,
  input  wire logic [REQ_W-1:0]     in_request_bytes,
  input  wire logic [ADDR_W-1:0]    in_release_address,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [ADDR_W-1:0]         out_data_address,
  output logic [STAT_W-1:0]         out_status
);

  localparam int unsigned OFF_W = $clog2(HEAP_BYTES);
  localparam int unsigned TOP_W = $clog2(HEAP_BYTES + 1);
  localparam int unsigned SUM_W = ((TOP_W > NEED_W) ? TOP_W : NEED_W) + 1;
  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

  typedef struct packed {
    logic             taken;
    logic [TOP_W-1:0] bytes;
    logic [OFF_W-1:0] start;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]    chk_idx_r, chk_idx_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic                cmd_r, cmd_nxt;
  logic [NEED_W-1:0]   need_r, need_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [ADDR_W-1:0]   heap_base_r, heap_base_nxt;
  logic [SIZE_W-1:0]   heap_size_r, heap_size_nxt;
  logic [CNT_W-1:0]    total_r, total_nxt;
  logic [TOP_W-1:0]    heap_top_r, heap_top_nxt;
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  logic [STAT_W-1:0]   res_stat_r, res_stat_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic [STAT_W-1:0]   out_stat_r, out_stat_nxt;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  entry_t              ram_wdata;
  entry_t              rd_entry;
  logic [$bits(entry_t)-1:0] ram_rdata;

  logic                accept;
  logic [NEED_W-1:0]   need_sum;
  logic [NEED_W-1:0]   in_need;
  logic                issue;
  logic                last;
  logic [ADDR_W-1:0]   chk_addr;
  logic                hit;
  logic [SUM_W-1:0]    limit;
  logic [SUM_W-1:0]    new_end;
  logic                no_space;
  logic [ADDR_W-1:0]   new_addr;

  ffha_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_BLOCKS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(scan_idx_r[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign need_sum  = NEED_W'(in_request_bytes) + NEED_W'(3);
  assign in_need   = {need_sum[NEED_W-1:2], 2'b00};

  assign issue     = (scan_idx_r < total_r);
  assign last      = ((chk_idx_r + CNT_W'(1)) == total_r);
  assign chk_addr  = heap_base_r + ADDR_W'(rd_entry.start) + ADDR_W'(HDR_BYTES);
  assign hit       = (cmd_r == CMD_ALLOC)
                     ? (!rd_entry.taken && (SUM_W'(rd_entry.bytes) >= SUM_W'(need_r)))
                     : (rd_entry.taken && (chk_addr == addr_r));

  assign limit     = (SUM_W'(heap_size_r) > SUM_W'(HEAP_BYTES))
                     ? SUM_W'(HEAP_BYTES) : SUM_W'(heap_size_r);
  assign new_end   = SUM_W'(heap_top_r) + SUM_W'(HDR_BYTES) + SUM_W'(need_r);
  assign no_space  = (total_r >= CNT_W'(MAX_BLOCKS)) || (new_end > limit);
  assign new_addr  = heap_base_r + ADDR_W'(heap_top_r) + ADDR_W'(HDR_BYTES);

  always_comb begin
    state_nxt     = state_r;
    scan_idx_nxt  = scan_idx_r;
    chk_idx_nxt   = chk_idx_r;
    chk_vld_nxt   = chk_vld_r;
    cmd_nxt       = cmd_r;
    need_nxt      = need_r;
    addr_nxt      = addr_r;
    heap_base_nxt = heap_base_r;
    heap_size_nxt = heap_size_r;
    total_nxt     = total_r;
    heap_top_nxt  = heap_top_r;
    res_addr_nxt  = res_addr_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_addr_nxt  = out_addr_r;
    out_stat_nxt  = out_stat_r;
    ram_we        = 1'b0;
    ram_waddr     = chk_idx_r[IDX_W-1:0];
    ram_wdata     = rd_entry;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_HEAP_BASE: heap_base_nxt = cfg_wdata;
        REG_HEAP_SIZE: heap_size_nxt = cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt      = in_cmd;
          need_nxt     = in_need;
          addr_nxt     = in_release_address;
          scan_idx_nxt = '0;
          chk_vld_nxt  = 1'b0;
          if (total_r == '0 || (in_cmd == CMD_FREE && in_release_address == '0)) begin
            if (in_cmd == CMD_ALLOC) begin
              state_nxt = S_PLACE;
            end else begin
              res_addr_nxt = '0;
              res_stat_nxt = STAT_IGNORED;
              state_nxt    = S_DONE;
            end
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (chk_vld_r && hit) begin
          ram_we          = 1'b1;
          ram_wdata.taken = (cmd_r == CMD_ALLOC);
          res_addr_nxt    = (cmd_r == CMD_ALLOC) ? chk_addr : addr_r;
          res_stat_nxt    = (cmd_r == CMD_ALLOC) ? STAT_REUSED : STAT_NEW;
          state_nxt       = S_DONE;
        end else if (chk_vld_r && last) begin
          if (cmd_r == CMD_ALLOC) begin
            state_nxt = S_PLACE;
          end else begin
            res_addr_nxt = '0;
            res_stat_nxt = STAT_IGNORED;
            state_nxt    = S_DONE;
          end
        end else begin
          chk_vld_nxt = issue;
          chk_idx_nxt = scan_idx_r;
          if (issue) begin
            scan_idx_nxt = scan_idx_r + CNT_W'(1);
          end
        end
      end
      S_PLACE: begin
        if (no_space) begin
          res_addr_nxt = '0;
          res_stat_nxt = STAT_NOSPACE;
        end else begin
          ram_we          = 1'b1;
          ram_waddr       = total_r[IDX_W-1:0];
          ram_wdata.taken = 1'b1;
          ram_wdata.bytes = TOP_W'(need_r);
          ram_wdata.start = OFF_W'(heap_top_r);
          total_nxt       = total_r + CNT_W'(1);
          heap_top_nxt    = TOP_W'(new_end);
          res_addr_nxt    = new_addr;
          res_stat_nxt    = STAT_NEW;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = res_addr_r;
          out_stat_nxt  = res_stat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_idx_r  <= '0;
      chk_idx_r   <= '0;
      chk_vld_r   <= 1'b0;
      heap_base_r <= '0;
      heap_size_r <= HEAP_SIZE_RST;
      total_r     <= '0;
      heap_top_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_idx_r  <= scan_idx_nxt;
      chk_idx_r   <= chk_idx_nxt;
      chk_vld_r   <= chk_vld_nxt;
      heap_base_r <= heap_base_nxt;
      heap_size_r <= heap_size_nxt;
      total_r     <= total_nxt;
      heap_top_r  <= heap_top_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    need_r     <= need_nxt;
    addr_r     <= addr_nxt;
    res_addr_r <= res_addr_nxt;
    res_stat_r <= res_stat_nxt;
    out_addr_r <= out_addr_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_data_address = out_addr_r;
  assign out_status       = out_stat_r;

endmodule

`default_nettype wire

@@ dv/tb_first_fit_heap_allocator.sv @@
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [STAT_W-1:0] status;
  } grant_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic                 cmd;
    logic [REQ_W-1:0]     req;
    logic [CFG_W-1:0]     word;
    logic [CFG_IDX_W-1:0] reg_idx;
    bit                   typed;
    grant_t               want;
  } script_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_cmd = CMD_ALLOC;
  logic [REQ_W-1:0]     in_request_bytes = '0;
  logic [ADDR_W-1:0]    in_release_address = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ADDR_W-1:0]    out_data_address;
  logic [STAT_W-1:0]    out_status;

  logic [ADDR_W-1:0] base_q = '0;
  logic [SIZE_W-1:0] size_q = HEAP_SIZE_RST;
  logic [11:0]       blk_start [MAX_BLOCKS_DEF];
  logic [SIZE_W-1:0] blk_bytes [MAX_BLOCKS_DEF];
  bit                blk_taken [MAX_BLOCKS_DEF];
  int unsigned       blk_total = 0;
  int unsigned       heap_top = 0;

  grant_t      grants_due [$];
  script_row_t directed_rows [$];
  grant_t      no_grant = '{addr: '0, status: '0};
  int unsigned fault_count = 0;
  int unsigned tx_gap_pct = 20;
  int unsigned rx_stall_pct = 20;
  bit          rx_hold_req = 1'b0;

  first_fit_heap_allocator dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_request_bytes   (in_request_bytes),
    .in_release_address (in_release_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_data_address   (out_data_address),
    .out_status         (out_status)
  );

  always #5 clk = ~clk;

  function automatic logic [ADDR_W-1:0] block_address(int unsigned k);
    return base_q + 32'(blk_start[k]) + 32'(HDR_BYTES);
  endfunction

  function automatic grant_t apply_heap_request(logic cmd, logic [REQ_W-1:0] req,
                                                logic [ADDR_W-1:0] addr);
    grant_t      g;
    int unsigned need;
    int unsigned limit;
    int unsigned k;
    g.addr = '0;
    if (cmd == CMD_ALLOC) begin
      need = (32'(req) + 32'd3) & ~32'd3;
      limit = (size_q > HEAP_BYTES_DEF) ? HEAP_BYTES_DEF : 32'(size_q);
      for (k = 0; k < blk_total; k++) begin
        if (!blk_taken[k] && 32'(blk_bytes[k]) >= need) begin
          blk_taken[k] = 1'b1;
          g.addr = block_address(k);
          g.status = STAT_REUSED;
          return g;
        end
      end
      if (blk_total >= MAX_BLOCKS_DEF || heap_top + HDR_BYTES + need > limit) begin
        g.status = STAT_NOSPACE;
        return g;
      end
      blk_start[blk_total] = heap_top[11:0];
      blk_bytes[blk_total] = need[SIZE_W-1:0];
      blk_taken[blk_total] = 1'b1;
      g.addr = block_address(blk_total);
      g.status = STAT_NEW;
      blk_total++;
      heap_top = heap_top + HDR_BYTES + need;
    end else begin
      g.status = STAT_IGNORED;
      if (addr != '0) begin
        for (k = 0; k < blk_total; k++) begin
          if (blk_taken[k] && block_address(k) == addr) begin
            blk_taken[k] = 1'b0;
            g.addr = addr;
            g.status = STAT_NEW;
            return g;
          end
        end
      end
    end
    return g;
  endfunction

  function automatic void alloc_row(logic [REQ_W-1:0] req, bit typed,
                                    logic [ADDR_W-1:0] exp_addr, logic [STAT_W-1:0] exp_stat);
    script_row_t r;
    r.kind = ROW_ITEM;
    r.cmd = CMD_ALLOC;
    r.req = req;
    r.word = 32'h5A5A_A5A5;
    r.reg_idx = REG_HEAP_BASE;
    r.typed = typed;
    r.want.addr = exp_addr;
    r.want.status = exp_stat;
    directed_rows.push_back(r);
  endfunction

  function automatic void free_row(logic [ADDR_W-1:0] addr, bit typed,
                                   logic [ADDR_W-1:0] exp_addr, logic [STAT_W-1:0] exp_stat);
    script_row_t r;
    r.kind = ROW_ITEM;
    r.cmd = CMD_FREE;
    r.req = 13'h1555;
    r.word = addr;
    r.reg_idx = REG_HEAP_BASE;
    r.typed = typed;
    r.want.addr = exp_addr;
    r.want.status = exp_stat;
    directed_rows.push_back(r);
  endfunction

  function automatic void cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    script_row_t r;
    r.kind = ROW_CFG;
    r.cmd = CMD_ALLOC;
    r.req = '0;
    r.word = data;
    r.reg_idx = idx;
    r.typed = 1'b0;
    r.want = no_grant;
    directed_rows.push_back(r);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_release_address();
    int unsigned live [$];
    int unsigned dead [$];
    int unsigned roll;
    int unsigned k;
    for (k = 0; k < blk_total; k++) begin
      if (blk_taken[k]) live.push_back(k);
      else dead.push_back(k);
    end
    roll = $urandom_range(0, 99);
    if (roll < 80 && live.size() != 0)
      return block_address(live[$urandom_range(0, live.size() - 1)]);
    if (roll < 90 && dead.size() != 0)
      return block_address(dead[$urandom_range(0, dead.size() - 1)]);
    if (roll < 93) return '0;
    return $urandom;
  endfunction

  function automatic logic [REQ_W-1:0] pick_request_bytes();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return REQ_W'($urandom_range(0, 64));
    if (roll < 90) return REQ_W'($urandom_range(0, 256));
    return REQ_W'($urandom_range(0, (1 << REQ_W) - 1));
  endfunction

  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 50;
    endcase
  endfunction

  task automatic sender_gap();
    if ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic send_item(logic cmd, logic [REQ_W-1:0] req, logic [ADDR_W-1:0] addr,
                           bit typed, grant_t want);
    grant_t g;
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_request_bytes <= req;
    in_release_address <= addr;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    g = apply_heap_request(cmd, req, addr);
    grants_due.push_back(typed ? want : g);
  endtask

  task automatic wait_for_grants();
    in_valid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    wait_for_grants();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HEAP_BASE) base_q = data;
    else size_q = data[SIZE_W-1:0];
  endtask

  always @(posedge clk) begin : grant_check
    grant_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (grants_due.size() == 0) begin
        fault_count++;
        $display("%0t: result with none expected: data_address %h status %0d",
                 $time, out_data_address, out_status);
      end else begin
        want = grants_due.pop_front();
        if (out_data_address !== want.addr) begin
          fault_count++;
          $display("%0t: data_address expected %h, actual %h",
                   $time, want.addr, out_data_address);
        end
        if (out_status !== want.status) begin
          fault_count++;
          $display("%0t: status expected %0d, actual %0d", $time, want.status, out_status);
        end
      end
    end
  end

  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < rx_stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned phase;
    logic [CFG_W-1:0] base_pick;
    logic [CFG_W-1:0] size_pick;
    for (int k = 0; k < MAX_BLOCKS_DEF; k++) begin
      blk_start[k] = '0;
      blk_bytes[k] = '0;
      blk_taken[k] = 1'b0;
    end

    // Blocks are laid out from offset zero: headers of 8 bytes, data rounded to words.
    alloc_row(13'd0, 1, 32'd8, STAT_NEW);
    alloc_row(13'd1, 1, 32'd16, STAT_NEW);
    alloc_row(13'd3, 1, 32'd28, STAT_NEW);
    alloc_row(13'd5, 1, 32'd40, STAT_NEW);
    free_row(32'd0, 1, 32'd0, STAT_IGNORED);
    free_row(32'd16, 1, 32'd16, STAT_NEW);
    free_row(32'd16, 1, 32'd0, STAT_IGNORED);
    free_row(32'd40, 1, 32'd40, STAT_NEW);
    // The 4-byte freed block is too small, so the 8-byte one further on is taken.
    alloc_row(13'd8, 0, '0, '0);
    alloc_row(13'd4, 1, 32'd16, STAT_REUSED);
    free_row(32'd8, 1, 32'd8, STAT_NEW);
    alloc_row(13'd0, 1, 32'd8, STAT_REUSED);
    free_row(32'hFFFF_FFFF, 1, 32'd0, STAT_IGNORED);
    free_row(32'd12, 1, 32'd0, STAT_IGNORED);
    alloc_row(13'd4096, 1, 32'd0, STAT_NOSPACE);
    alloc_row(13'h1FFF, 1, 32'd0, STAT_NOSPACE);
    // The heap top is at 48, so a limit of 72 leaves exactly one 16-byte block.
    cfg_row(REG_HEAP_SIZE, 32'd72);
    alloc_row(13'd17, 1, 32'd0, STAT_NOSPACE);
    alloc_row(13'd16, 0, '0, '0);
    alloc_row(13'd0, 1, 32'd0, STAT_NOSPACE);
    cfg_row(REG_HEAP_SIZE, 32'd8);
    alloc_row(13'd0, 1, 32'd0, STAT_NOSPACE);
    // Data addresses follow the base and wrap past the top of the address space.
    cfg_row(REG_HEAP_BASE, 32'hFFFF_FFFC);
    free_row(32'd4, 1, 32'd4, STAT_NEW);
    free_row(32'd8, 1, 32'd0, STAT_IGNORED);
    alloc_row(13'd0, 0, '0, '0);
    cfg_row(REG_HEAP_BASE, 32'd3);
    free_row(32'd19, 1, 32'd19, STAT_NEW);
    alloc_row(13'd2, 0, '0, '0);
    cfg_row(REG_HEAP_SIZE, 32'h1FFF);
    cfg_row(REG_HEAP_BASE, 32'd0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_reg(directed_rows[i].reg_idx, directed_rows[i].word);
      end else begin
        sender_gap();
        send_item(directed_rows[i].cmd, directed_rows[i].req, directed_rows[i].word,
                  directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 3))
        0: base_pick = '0;
        1: base_pick = 32'hFFFF_FFFC;
        2: base_pick = $urandom & ~32'd3;
        default: base_pick = $urandom;
      endcase
      case ($urandom_range(0, 3))
        0: size_pick = 32'd8191;
        1: size_pick = $urandom_range(8, 4096);
        default: size_pick = 32'd4096;
      endcase
      if (phase == 3) size_pick = 32'd8;
      write_reg(REG_HEAP_BASE, base_pick);
      write_reg(REG_HEAP_SIZE, size_pick);
      tx_gap_pct = (phase == 7) ? 0 : pick_idle_pct();
      rx_stall_pct = (phase == 7) ? 0 : pick_idle_pct();
      if (phase == 1) rx_hold_req = 1'b1;
      repeat (250) begin
        sender_gap();
        if ($urandom_range(0, 99) < 55)
          send_item(CMD_ALLOC, pick_request_bytes(), $urandom, 1'b0, no_grant);
        else
          send_item(CMD_FREE, REQ_W'($urandom), pick_release_address(), 1'b0, no_grant);
      end
    end

    wait_for_grants();
    repeat (80) @(posedge clk);
    if (fault_count == 0 && grants_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
